### rtl/core/assert_macros.svh
// Assertion macros for the RTL of the bit-sliced compare scan.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/bscs_pkg.sv
// Package for the bit-sliced column compare scan: sizes, codes, config type.
// No dependencies; imported by the top level.
`default_nettype none

package bscs_pkg;

    // Sizes
    localparam int LANES      = 64;
    localparam int MAX_SLICES = 32;
    localparam int WORD_W     = 64;
    localparam int LIT_W      = 32;
    localparam int LIT_IDX_W  = 5;
    localparam int CNT_W      = 6;
    localparam int LANE_CNT_W = 7;
    localparam int SLICE_W    = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_OP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMBINE_OP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_USE_OTHER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LITERAL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_COUNT = 3'd4;

    // Compare operations
    localparam logic [2:0] CMP_LT = 3'd0;
    localparam logic [2:0] CMP_GT = 3'd1;
    localparam logic [2:0] CMP_LE = 3'd2;
    localparam logic [2:0] CMP_GE = 3'd3;
    localparam logic [2:0] CMP_EQ = 3'd4;
    localparam logic [2:0] CMP_NE = 3'd5;

    // Combine operations
    localparam logic [1:0] COMB_SET = 2'd0;
    localparam logic [1:0] COMB_AND = 2'd1;
    localparam logic [1:0] COMB_OR  = 2'd2;

    localparam logic [CNT_W-1:0] SLICE_COUNT_RESET = 6'd8;

    typedef struct packed {
        logic [2:0]       compare_op;
        logic [1:0]       combine_op;
        logic             use_other_column;
        logic [LIT_W-1:0] literal_value;
        logic [CNT_W-1:0] slice_count;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/core/bit_sliced_column_compare_scan.sv
// A slice transaction is captured in the input register, then folded into the lane
// masks; the result of a last slice is then held in the result register.
// Throughput: one slice word per cycle unless a last slice waits on a full result register.
// Reset (async, rst_n low): config to defaults (slice_count 8, others 0),
// less/greater masks cleared, equal mask all ones, slice index 0, no result.
// Top level of the bit-sliced compare scan; depends on bscs_pkg, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bit_sliced_column_compare_scan
    import bscs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // slice input channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [WORD_W-1:0]     slice_bits,
    input  wire logic [WORD_W-1:0]     other_bits,
    input  wire logic [WORD_W-1:0]     prior_bits,
    input  wire logic                  last_slice,
    input  wire logic [LANE_CNT_W-1:0] valid_lanes,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [WORD_W-1:0]          result_bits
);

    cfg_t cfg_reg;

    logic                  in_valid_reg;
    logic [WORD_W-1:0]     slice_reg;
    logic [WORD_W-1:0]     other_reg;
    logic [WORD_W-1:0]     prior_reg;
    logic                  last_reg;
    logic [LANE_CNT_W-1:0] lanes_reg;

    logic [WORD_W-1:0]  less_mask_reg;
    logic [WORD_W-1:0]  greater_mask_reg;
    logic [WORD_W-1:0]  equal_mask_reg;
    logic [SLICE_W-1:0] slice_index_reg;

    logic               out_valid_reg;
    logic [WORD_W-1:0]  result_reg;

    logic               stage_adv;
    logic               first_slice;
    logic [WORD_W-1:0]  less_base;
    logic [WORD_W-1:0]  greater_base;
    logic [WORD_W-1:0]  equal_base;
    logic [WORD_W-1:0]  comparand;
    logic               lit_bit;
    logic [LANE_CNT_W-1:0] idx_ext;
    logic [LANE_CNT_W-1:0] cnt_ext;
    logic [LANE_CNT_W-1:0] lit_pos;
    logic [WORD_W-1:0]  less_next;
    logic [WORD_W-1:0]  greater_next;
    logic [WORD_W-1:0]  equal_next;
    logic [WORD_W-1:0]  predicate;
    logic [WORD_W-1:0]  combined;
    logic [WORD_W-1:0]  lane_mask;
    logic [WORD_W-1:0]  result_next;

    // Config port: always ready; writes are registered into cfg_reg
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.compare_op       <= CMP_LT;
            cfg_reg.combine_op       <= COMB_SET;
            cfg_reg.use_other_column <= 1'b0;
            cfg_reg.literal_value    <= '0;
            cfg_reg.slice_count      <= SLICE_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_COMPARE_OP:  cfg_reg.compare_op       <= cfg_data[2:0];
                REG_COMBINE_OP:  cfg_reg.combine_op       <= cfg_data[1:0];
                REG_USE_OTHER:   cfg_reg.use_other_column <= cfg_data[0];
                REG_LITERAL:     cfg_reg.literal_value    <= cfg_data[LIT_W-1:0];
                REG_SLICE_COUNT: cfg_reg.slice_count      <= cfg_data[CNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Handshake: stage stalls only when a last slice cannot place its result
    assign stage_adv = in_valid_reg && (!last_reg || !out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || stage_adv;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            slice_reg <= slice_bits;
            other_reg <= other_bits;
            prior_reg <= prior_bits;
            last_reg  <= last_slice;
            lanes_reg <= valid_lanes;
        end
    end

    // Mask seeds at the first slice of a segment
    assign first_slice = (slice_index_reg == '0);

    always_comb
    begin
        less_base    = less_mask_reg;
        greater_base = greater_mask_reg;
        equal_base   = equal_mask_reg;
        if (first_slice)
        begin
            less_base    = '0;
            greater_base = '0;
            if (cfg_reg.combine_op == COMB_AND)
                equal_base = prior_reg;
            else if (cfg_reg.combine_op == COMB_OR)
                equal_base = ~prior_reg;
            else
                equal_base = '1;
        end
    end

    // Literal bit for this slice; zero when out of range or above bit 31
    assign idx_ext = LANE_CNT_W'(slice_index_reg);
    assign cnt_ext = LANE_CNT_W'(cfg_reg.slice_count);
    assign lit_pos = cnt_ext - idx_ext - LANE_CNT_W'(1);

    always_comb
    begin
        lit_bit = 1'b0;
        if ((idx_ext < cnt_ext) && (lit_pos < LANE_CNT_W'(LIT_W)))
            lit_bit = cfg_reg.literal_value[lit_pos[LIT_IDX_W-1:0]];
    end

    assign comparand = cfg_reg.use_other_column ? other_reg : {WORD_W{lit_bit}};

    // Per-lane compare update
    assign less_next    = less_base    | (equal_base & ~slice_reg & comparand);
    assign greater_next = greater_base | (equal_base & slice_reg & ~comparand);
    assign equal_next   = equal_base   & ~(slice_reg ^ comparand);

    // Predicate word
    always_comb
    begin
        unique case (cfg_reg.compare_op)
            CMP_LT:  predicate = less_next;
            CMP_GT:  predicate = greater_next;
            CMP_LE:  predicate = less_next | equal_next;
            CMP_GE:  predicate = greater_next | equal_next;
            CMP_EQ:  predicate = equal_next;
            CMP_NE:  predicate = ~equal_next;
            default: predicate = '0;
        endcase
    end

    always_comb
    begin
        unique case (cfg_reg.combine_op)
            COMB_AND: combined = predicate & prior_reg;
            COMB_OR:  combined = predicate | prior_reg;
            default:  combined = predicate;
        endcase
    end

    // Lanes at or above valid_lanes (or LANES) are cleared
    always_comb
    begin
        for (int i = 0; i < WORD_W; i++)
            lane_mask[i] = (i < LANES) && (LANE_CNT_W'(i) < lanes_reg);
    end

    assign result_next = combined & lane_mask;

    // Mask state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            less_mask_reg    <= '0;
            greater_mask_reg <= '0;
            equal_mask_reg   <= '1;
            slice_index_reg  <= '0;
        end
        else if (stage_adv)
        begin
            if (last_reg)
            begin
                less_mask_reg    <= '0;
                greater_mask_reg <= '0;
                equal_mask_reg   <= '1;
                slice_index_reg  <= '0;
            end
            else
            begin
                less_mask_reg    <= less_next;
                greater_mask_reg <= greater_next;
                equal_mask_reg   <= equal_next;
                if (slice_index_reg != SLICE_W'(MAX_SLICES - 1))
                    slice_index_reg <= slice_index_reg + SLICE_W'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stage_adv && last_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stage_adv && last_reg)
            result_reg <= result_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_bits = result_reg;

    // Checks
    `ASSERT_NEXT(a_last_gives_result, clk, rst_n, stage_adv && last_reg, out_valid_reg)
    `ASSERT_NEXT(a_last_rewinds_index, clk, rst_n, stage_adv && last_reg,
                 slice_index_reg == '0)
    `ASSERT_NEXT(a_last_reseeds_equal, clk, rst_n, stage_adv && last_reg,
                 equal_mask_reg == '1)
    `ASSERT_IMPLY(a_stall_only_on_full_result, clk, rst_n, !in_ready,
                  in_valid_reg && last_reg && out_valid_reg && !out_ready)

endmodule

`default_nettype wire
